@@ rtl/kst_pkg.sv @@
// Package for the keyed status table: table sizing, entry layout and request,
// result and status codes. No dependencies.
package kst_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_OFFLINE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd1;

    typedef enum logic [2:0] {
        REQ_ADD         = 3'd0,
        REQ_REMOVE      = 3'd1,
        REQ_BLOCK       = 3'd2,
        REQ_SET_STATUS  = 3'd3,
        REQ_LOOKUP      = 3'd4,
        REQ_ALL_OFFLINE = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_NOT_READY = 2'd1,
        RC_FULL      = 2'd2,
        RC_MISSING   = 2'd3
    } t_rc;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [STATUS_W-1:0] status;
    } t_entry;

endpackage

@@ rtl/kst_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependencies.
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/keyed_status_table.sv @@
// Keyed status table: compacted key/status table held in one synchronous RAM.
// Requests refused at once or undefined go straight to the result; searches scan
// the valid entries in RAM, a remove that hits then shifts the rest down, and all
// offline sweeps every entry. One request at a time: the block is ready for the next
// word in the cycle after the result enters the output register. Reset clears the
// entry count and the handshake state.
module keyed_status_table
    import kst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_req_type,
    input  logic [KEY_W-1:0]    i_profile_id,
    input  logic [STATUS_W-1:0] i_new_status,
    input  logic                i_session_ready,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_result_code,
    output logic                o_found,
    output logic [4:0]          o_entry_index,
    output logic [STATUS_W-1:0] o_entry_status,
    output logic [5:0]          o_entry_count
);

    // IDLE takes a word, SEARCH walks the valid entries looking for the key,
    // SHIFT closes the gap left by a remove, SWEEP sets every status that is not
    // blocked to offline, and DONE hands the result to the output register.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state                r_state;
    t_req                  r_req;
    logic [KEY_W-1:0]      r_key;
    logic [STATUS_W-1:0]   r_nst;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_ptr;   // next RAM address to read
    logic                  r_pend;  // read data of the previous cycle is valid
    logic [IDX_W-1:0]      r_cmp;   // address the pending data belongs to / targets

    // Result being built.
    t_rc                   r_code;
    logic                  r_fnd;
    logic [IDX_W-1:0]      r_idx;
    logic [STATUS_W-1:0]   r_st;

    // Output register.
    logic                  r_out_valid;
    logic [1:0]            r_result_code;
    logic                  r_found;
    logic [4:0]            r_entry_index;
    logic [STATUS_W-1:0]   r_entry_status;
    logic [5:0]            r_entry_count;

    // RAM port signals.
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_entry                ram_wdata;
    logic                  ram_re;
    t_entry                ram_rdata;

    logic                  hit;
    logic                  scan_end;
    logic                  has_room;
    logic [CNT_W-1:0]      ptr_dec;
    logic [CNT_W-1:0]      cmp_inc;

    kst_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign hit      = r_pend && (ram_rdata.key == r_key);
    assign scan_end = (r_ptr >= r_count);
    assign has_room = (r_count < CNT_W'(TABLE_DEPTH));
    assign ptr_dec  = r_ptr - CNT_W'(1);
    assign cmp_inc  = CNT_W'(r_cmp) + CNT_W'(1);

    // RAM control. Writes always trail the reads, so a read never meets a write
    // to the same entry within one request.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cmp;
        ram_wdata = '{key: r_key, status: ST_OFFLINE};
        ram_re    = 1'b0;
        case (r_state)
            S_SEARCH: begin
                if (hit) begin
                    if (r_req == REQ_SET_STATUS) begin
                        ram_we    = 1'b1;
                        ram_wdata = '{key: r_key, status: r_nst};
                    end else if (r_req == REQ_BLOCK) begin
                        ram_we    = 1'b1;
                        ram_wdata = '{key: r_key, status: ST_BLOCKED};
                    end
                end else if (scan_end) begin
                    // Add, or block with room, appends at the table end on a miss.
                    ram_waddr = r_count[IDX_W-1:0];
                    if (r_req == REQ_ADD) begin
                        ram_we = 1'b1;
                    end else if (r_req == REQ_BLOCK && has_room) begin
                        ram_we    = 1'b1;
                        ram_wdata = '{key: r_key, status: ST_BLOCKED};
                    end
                end else begin
                    ram_re = 1'b1;
                end
            end
            S_SHIFT: begin
                // Entry read last cycle moves down one place.
                ram_we    = r_pend;
                ram_wdata = ram_rdata;
                ram_re    = !scan_end;
            end
            S_SWEEP: begin
                ram_we    = r_pend && (ram_rdata.status != ST_BLOCKED);
                ram_wdata = '{key: ram_rdata.key, status: ST_OFFLINE};
                ram_re    = !scan_end;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In DONE the output register is reloaded whenever the receiver takes
            // a word, so the valid flag is only cleared in the other states.
            if (i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req  <= t_req'(i_req_type);
                        r_key  <= i_profile_id;
                        r_nst  <= i_new_status;
                        r_ptr  <= '0;
                        r_pend <= 1'b0;
                        r_fnd  <= 1'b0;
                        r_idx  <= '0;
                        r_st   <= ST_OFFLINE;
                        case (i_req_type)
                            REQ_ADD, REQ_REMOVE, REQ_BLOCK: begin
                                if (!i_session_ready) begin
                                    r_code  <= RC_NOT_READY;
                                    r_state <= S_DONE;
                                end else if (i_req_type == REQ_ADD && !has_room) begin
                                    // A full table refuses an add before any key check.
                                    r_code  <= RC_FULL;
                                    r_state <= S_DONE;
                                end else begin
                                    r_code  <= RC_OK;
                                    r_state <= S_SEARCH;
                                end
                            end
                            REQ_SET_STATUS, REQ_LOOKUP: begin
                                r_code  <= RC_OK;
                                r_state <= S_SEARCH;
                            end
                            REQ_ALL_OFFLINE: begin
                                r_code  <= RC_OK;
                                r_state <= S_SWEEP;
                            end
                            default: begin
                                // Unknown requests answer OK and change nothing.
                                r_code  <= RC_OK;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        r_fnd  <= 1'b1;
                        r_idx  <= r_cmp;
                        r_pend <= 1'b0;
                        case (r_req)
                            REQ_SET_STATUS: r_st <= r_nst;
                            REQ_BLOCK:      r_st <= ST_BLOCKED;
                            default:        r_st <= ram_rdata.status;
                        endcase
                        if (r_req == REQ_REMOVE) begin
                            r_ptr   <= cmp_inc;
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (scan_end) begin
                        case (r_req)
                            REQ_ADD: begin
                                r_idx   <= r_count[IDX_W-1:0];
                                r_st    <= ST_OFFLINE;
                                r_count <= r_count + CNT_W'(1);
                            end
                            REQ_BLOCK: begin
                                if (has_room) begin
                                    r_idx   <= r_count[IDX_W-1:0];
                                    r_st    <= ST_BLOCKED;
                                    r_count <= r_count + CNT_W'(1);
                                end else begin
                                    r_code <= RC_FULL;
                                end
                            end
                            default: begin
                                r_code <= RC_MISSING;
                            end
                        endcase
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_pend <= 1'b1;
                        r_cmp  <= r_ptr[IDX_W-1:0];
                        r_ptr  <= r_ptr + CNT_W'(1);
                    end
                end
                S_SHIFT: begin
                    if (scan_end) begin
                        r_count <= r_count - CNT_W'(1);
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_pend <= 1'b1;
                        r_cmp  <= ptr_dec[IDX_W-1:0];
                        r_ptr  <= r_ptr + CNT_W'(1);
                    end
                end
                S_SWEEP: begin
                    if (scan_end) begin
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_pend <= 1'b1;
                        r_cmp  <= r_ptr[IDX_W-1:0];
                        r_ptr  <= r_ptr + CNT_W'(1);
                    end
                end
                S_DONE: begin
                    // Move the result into the output register once it is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_result_code  <= r_code;
                        r_found        <= r_fnd;
                        r_entry_index  <= 5'(r_idx);
                        r_entry_status <= r_st;
                        r_entry_count  <= 6'(r_count);
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_code  = r_result_code;
    assign o_found        = r_found;
    assign o_entry_index  = r_entry_index;
    assign o_entry_status = r_entry_status;
    assign o_entry_count  = r_entry_count;

endmodule

@@ test/tb_keyed_status_table.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keyed_status_table: a directed table of requests,
// then random request streams checked against a behavioral model of the table.
// Depends on kst_pkg and the keyed_status_table RTL (with kst_ram) only.
module tb_keyed_status_table;
    import kst_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 5;
    localparam int N_RANDOM       = 750;
    localparam int POOL_SIZE      = 24;
    // The output side stops taking words for this long once, after HOLD_AT results.
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT        = 60;
    // Longest legal quiet stretch is the long hold, well under this.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 200;

    // Request codes 6 and 7 are not defined; the block answers them without effect.
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam logic [STATUS_W-1:0] ST_IN_GAME = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ONLINE7 = 3'd7;

    localparam logic [KEY_W-1:0] KEY_MIN   = 32'h0000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX   = 32'hFFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ALT_A = 32'hA5A5_A5A5;
    localparam logic [KEY_W-1:0] KEY_ALT_B = 32'h5A5A_5A5A;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} t_mode;

    // Request mix per traffic mode, in percent. Columns follow the request codes
    // (add, remove, block, set status, lookup, all offline); the last column is
    // the share of undefined codes.
    localparam int REQ_WEIGHT [3][7] = '{
        '{50,  6, 14, 12, 12, 4, 2},
        '{10, 45,  5, 14, 18, 5, 3},
        '{28, 22, 10, 18, 15, 5, 2}
    };

    typedef struct packed {
        logic [2:0]          req;
        logic [KEY_W-1:0]    key;
        logic [STATUS_W-1:0] nst;
        logic                ready;
    } t_request;

    typedef struct packed {
        t_rc                 code;
        logic                found;
        logic [IDX_W-1:0]    index;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
    } t_result;

    // One row of the directed table. Where typed is set, the row carries its own
    // expected answer; otherwise the answer comes from the table model.
    typedef struct packed {
        logic [2:0]          req;
        logic [KEY_W-1:0]    key;
        logic [STATUS_W-1:0] nst;
        logic                ready;
        logic                typed;
        t_rc                 code;
        logic                found;
        logic [IDX_W-1:0]    index;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
    } t_row;

    localparam int N_DIRECTED = 24;

    // The table starts empty; every request kind, the not-ready and missing codes, the
    // all-zero and all-one keys and both ends of new_status show up here.
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // Empty table: every search misses, an add without a session is refused.
        '{REQ_LOOKUP, KEY_MIN, ST_OFFLINE, 1'b1, 1'b1, RC_MISSING, 1'b0, 5'd0, ST_OFFLINE, 6'd0},
        '{REQ_SET_STATUS, KEY_MIN, ST_ONLINE7, 1'b1, 1'b1, RC_MISSING, 1'b0, 5'd0, ST_OFFLINE,
          6'd0},
        '{REQ_REMOVE, KEY_MIN, ST_OFFLINE, 1'b1, 1'b1, RC_MISSING, 1'b0, 5'd0, ST_OFFLINE, 6'd0},
        '{REQ_ADD, KEY_MIN, ST_OFFLINE, 1'b0, 1'b1, RC_NOT_READY, 1'b0, 5'd0, ST_OFFLINE, 6'd0},
        // Two appends, then a duplicate add that leaves the entry as it was.
        '{REQ_ADD, KEY_MIN, ST_OFFLINE, 1'b1, 1'b1, RC_OK, 1'b0, 5'd0, ST_OFFLINE, 6'd1},
        '{REQ_ADD, KEY_MAX, ST_OFFLINE, 1'b1, 1'b1, RC_OK, 1'b0, 5'd1, ST_OFFLINE, 6'd2},
        '{REQ_ADD, KEY_MAX, ST_OFFLINE, 1'b1, 1'b1, RC_OK, 1'b1, 5'd1, ST_OFFLINE, 6'd2},
        // Set status does not need the session.
        '{REQ_SET_STATUS, KEY_MAX, ST_ONLINE7, 1'b0, 1'b1, RC_OK, 1'b1, 5'd1, ST_ONLINE7, 6'd2},
        // Block of a present key, then of a new key that gets appended blocked.
        '{REQ_BLOCK, KEY_MIN, ST_OFFLINE, 1'b1, 1'b1, RC_OK, 1'b1, 5'd0, ST_BLOCKED, 6'd2},
        '{REQ_BLOCK, KEY_ALT_A, ST_OFFLINE, 1'b1, 1'b1, RC_OK, 1'b0, 5'd2, ST_BLOCKED, 6'd3},
        '{REQ_REMOVE, KEY_MAX, ST_OFFLINE, 1'b0, 1'b1, RC_NOT_READY, 1'b0, 5'd0, ST_OFFLINE, 6'd3},
        '{REQ_BLOCK, KEY_ALT_B, ST_OFFLINE, 1'b0, 1'b1, RC_NOT_READY, 1'b0, 5'd0, ST_OFFLINE, 6'd3},
        '{REQ_SET_STATUS, KEY_ALT_B, ST_IN_GAME, 1'b1, 1'b1, RC_MISSING, 1'b0, 5'd0, ST_OFFLINE,
          6'd3},
        '{REQ_LOOKUP, KEY_ALT_B, ST_OFFLINE, 1'b1, 1'b1, RC_MISSING, 1'b0, 5'd0, ST_OFFLINE, 6'd3},
        // A blocked entry may be given another status directly.
        '{REQ_SET_STATUS, KEY_ALT_A, ST_IN_GAME, 1'b1, 1'b1, RC_OK, 1'b1, 5'd2, ST_IN_GAME, 6'd3},
        // All offline runs without a session and spares the blocked entry.
        '{REQ_ALL_OFFLINE, KEY_MIN, ST_OFFLINE, 1'b0, 1'b1, RC_OK, 1'b0, 5'd0, ST_OFFLINE, 6'd3},
        '{REQ_LOOKUP, KEY_MAX, ST_OFFLINE, 1'b1, 1'b1, RC_OK, 1'b1, 5'd1, ST_OFFLINE, 6'd3},
        // Removing the head reports its blocked status and shifts the rest down.
        '{REQ_REMOVE, KEY_MIN, ST_OFFLINE, 1'b1, 1'b1, RC_OK, 1'b1, 5'd0, ST_BLOCKED, 6'd2},
        '{REQ_LOOKUP, KEY_ALT_A, ST_OFFLINE, 1'b1, 1'b0, RC_OK, 1'b0, 5'd0, ST_OFFLINE, 6'd0},
        '{REQ_SPARE_6, KEY_MAX, ST_ONLINE7, 1'b1, 1'b1, RC_OK, 1'b0, 5'd0, ST_OFFLINE, 6'd2},
        '{REQ_SPARE_7, KEY_MAX, ST_ONLINE7, 1'b0, 1'b1, RC_OK, 1'b0, 5'd0, ST_OFFLINE, 6'd2},
        '{REQ_ADD, KEY_MAX, ST_ONLINE7, 1'b1, 1'b0, RC_OK, 1'b0, 5'd0, ST_OFFLINE, 6'd0},
        '{REQ_REMOVE, KEY_ALT_A, ST_OFFLINE, 1'b1, 1'b0, RC_OK, 1'b0, 5'd0, ST_OFFLINE, 6'd0},
        '{REQ_REMOVE, KEY_MAX, ST_OFFLINE, 1'b1, 1'b0, RC_OK, 1'b0, 5'd0, ST_OFFLINE, 6'd0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [2:0]          i_req_type;
    logic [KEY_W-1:0]    i_profile_id;
    logic [STATUS_W-1:0] i_new_status;
    logic                i_session_ready;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [1:0]          o_result_code;
    logic                o_found;
    logic [IDX_W-1:0]    o_entry_index;
    logic [STATUS_W-1:0] o_entry_status;
    logic [CNT_W-1:0]    o_entry_count;

    // Behavioral copy of the table: compacted, entries 0 .. tbl_count-1 valid.
    logic [KEY_W-1:0]    tbl_key    [TABLE_DEPTH];
    logic [STATUS_W-1:0] tbl_status [TABLE_DEPTH];
    int                  tbl_count = 0;

    // Answers owed by the block, oldest first.
    t_result             pending_answers [$];

    logic [KEY_W-1:0]    key_pool [POOL_SIZE];

    int  n_errors    = 0;
    int  n_results   = 0;
    int  n_sent      = 0;
    int  n_random    = 0;
    int  peak_count  = 0;
    int  code_seen [4] = '{0, 0, 0, 0};
    int  next_gap    = 1;
    int  stall_left  = 0;
    int  idle_cycles = 0;
    bit  quiet       = 1'b0;
    bit  hold_done   = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    keyed_status_table u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_profile_id    (i_profile_id),
        .i_new_status    (i_new_status),
        .i_session_ready (i_session_ready),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_code   (o_result_code),
        .o_found         (o_found),
        .o_entry_index   (o_entry_index),
        .o_entry_status  (o_entry_status),
        .o_entry_count   (o_entry_count)
    );

    // Applies one request to the table model and returns the answer it owes.
    // The search always takes the first matching key from position 0 upward.
    function automatic t_result apply_request(t_request rq);
        t_result res;
        int      hit;
        res = '0;
        hit = -1;
        for (int i = tbl_count - 1; i >= 0; i--)
            if (tbl_key[i] == rq.key) hit = i;
        case (rq.req)
            REQ_ADD: begin
                // A full table is refused before the duplicate check.
                if (!rq.ready) res.code = RC_NOT_READY;
                else if (tbl_count == TABLE_DEPTH) res.code = RC_FULL;
                else if (hit >= 0) begin
                    res.found  = 1'b1;
                    res.index  = IDX_W'(hit);
                    res.status = tbl_status[hit];
                end else begin
                    res.index = IDX_W'(tbl_count);
                    res.status = ST_OFFLINE;
                    tbl_key[tbl_count]    = rq.key;
                    tbl_status[tbl_count] = ST_OFFLINE;
                    tbl_count++;
                end
            end
            REQ_REMOVE: begin
                if (!rq.ready) res.code = RC_NOT_READY;
                else if (hit < 0) res.code = RC_MISSING;
                else begin
                    res.found  = 1'b1;
                    res.index  = IDX_W'(hit);
                    res.status = tbl_status[hit];
                    for (int i = hit; i < tbl_count - 1; i++) begin
                        tbl_key[i]    = tbl_key[i + 1];
                        tbl_status[i] = tbl_status[i + 1];
                    end
                    tbl_count--;
                end
            end
            REQ_BLOCK: begin
                if (!rq.ready) res.code = RC_NOT_READY;
                else if (hit >= 0) begin
                    res.found  = 1'b1;
                    res.index  = IDX_W'(hit);
                    res.status = ST_BLOCKED;
                    tbl_status[hit] = ST_BLOCKED;
                end else if (tbl_count < TABLE_DEPTH) begin
                    res.index  = IDX_W'(tbl_count);
                    res.status = ST_BLOCKED;
                    tbl_key[tbl_count]    = rq.key;
                    tbl_status[tbl_count] = ST_BLOCKED;
                    tbl_count++;
                end else res.code = RC_FULL;
            end
            REQ_SET_STATUS: begin
                if (hit < 0) res.code = RC_MISSING;
                else begin
                    res.found  = 1'b1;
                    res.index  = IDX_W'(hit);
                    res.status = rq.nst;
                    tbl_status[hit] = rq.nst;
                end
            end
            REQ_LOOKUP: begin
                if (hit < 0) res.code = RC_MISSING;
                else begin
                    res.found  = 1'b1;
                    res.index  = IDX_W'(hit);
                    res.status = tbl_status[hit];
                end
            end
            REQ_ALL_OFFLINE: begin
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_status[i] != ST_BLOCKED) tbl_status[i] = ST_OFFLINE;
            end
            default: begin
            end
        endcase
        res.count = CNT_W'(tbl_count);
        return res;
    endfunction

    // Idle gap between words: mostly none, sometimes a few cycles, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Keys lean toward entries already in the table so that searches hit often.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60 && tbl_count > 0) return tbl_key[$urandom_range(0, tbl_count - 1)];
        if (r < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic t_request random_request(t_mode mode);
        t_request rq;
        int       r;
        int       acc;
        int       sel;
        r   = $urandom_range(0, 99);
        acc = 0;
        sel = -1;
        for (int k = 0; k < 7; k++) begin
            acc += REQ_WEIGHT[mode][k];
            if (sel < 0 && r < acc) sel = k;
        end
        if (sel == 6) rq.req = $urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6;
        else rq.req = 3'(sel);
        rq.key   = pick_key();
        rq.nst   = 3'($urandom_range(0, 7));
        rq.ready = ($urandom_range(0, 9) != 0);
        return rq;
    endfunction

    // Offers one word and holds it until the block takes it. Valid is dropped
    // after the handshake only when a gap follows, so it never toggles within
    // one time step.
    task automatic send_request(t_request rq, bit use_given, t_result given);
        t_result res;
        if (next_gap > 0) repeat (next_gap) @(posedge i_clk);
        i_in_valid      <= 1'b1;
        i_req_type      <= rq.req;
        i_profile_id    <= rq.key;
        i_new_status    <= rq.nst;
        i_session_ready <= rq.ready;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = apply_request(rq);
        pending_answers.push_back(use_given ? given : res);
        n_sent++;
        if (tbl_count > peak_count) peak_count = tbl_count;
        next_gap = pick_gap();
        if (next_gap > 0) i_in_valid <= 1'b0;
    endtask

    // Stops offering words until every owed answer has come back.
    task automatic wait_for_results();
        if (next_gap == 0) begin
            i_in_valid <= 1'b0;
            next_gap = 1;
        end
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // Adds fresh keys until the table is full, so that the full-table refusals
    // and long compaction shifts get exercised.
    task automatic fill_table();
        t_request rq;
        while (tbl_count < TABLE_DEPTH) begin
            rq.req   = REQ_ADD;
            rq.key   = $urandom;
            rq.nst   = 3'($urandom_range(0, 7));
            rq.ready = 1'b1;
            send_request(rq, 1'b0, '0);
            n_random++;
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: result %0d, %s expected %0d, got %0d",
                         $time, n_results, name, want, got);
        end
    endtask

    task automatic check_result();
        t_result want;
        n_results++;
        code_seen[o_result_code]++;
        if (pending_answers.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: result %0d, expected no word, got code %0d",
                         $time, n_results, o_result_code);
        end else begin
            want = pending_answers.pop_front();
            check_field("result_code", want.code, o_result_code);
            check_field("found", want.found, o_found);
            check_field("entry_index", want.index, o_entry_index);
            check_field("entry_status", want.status, o_entry_status);
            check_field("entry_count", want.count, o_entry_count);
        end
    endtask

    // Output side: checks every word taken, stalls at random, and once holds off
    // long enough that the block backs up and stops taking requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) check_result();
            if (n_results == HOLD_AT && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 20) stall_left = pick_gap();
            end
        end
    end

    // Watchdog: a run in which no word moves on either side for too long is hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_row     row;
        t_request rq;
        t_result  given;
        t_mode    mode;
        int       len;
        int       seg;

        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_req_type      <= REQ_LOOKUP;
        i_profile_id    <= KEY_MIN;
        i_new_status    <= ST_OFFLINE;
        i_session_ready <= 1'b0;

        // The all-zero and all-one keys stay in the pool; the rest are random.
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            row          = DIRECTED_ROWS[i];
            rq.req       = row.req;
            rq.key       = row.key;
            rq.nst       = row.nst;
            rq.ready     = row.ready;
            given.code   = row.code;
            given.found  = row.found;
            given.index  = row.index;
            given.status = row.status;
            given.count  = row.count;
            send_request(rq, row.typed, given);
        end
        wait_for_results();

        // Random traffic in segments. Each segment either fills the table and
        // then pokes at it, or runs a growing, shrinking or mixed request stream.
        // Some segments run with no idling on either side, and some end with the
        // sender waiting for the block to drain.
        seg = 0;
        while (n_random < N_RANDOM) begin
            quiet = ($urandom_range(0, 4) == 0);
            if (seg == 0 || $urandom_range(0, 4) == 0) begin
                fill_table();
                mode = MODE_GROW;
                len  = 10;
            end else begin
                mode = t_mode'($urandom_range(0, 2));
                len  = $urandom_range(20, 60);
            end
            repeat (len) begin
                rq = random_request(mode);
                send_request(rq, 1'b0, '0);
                if (rq.req <= REQ_ALL_OFFLINE) n_random++;
            end
            if ($urandom_range(0, 3) == 0) wait_for_results();
            seg++;
        end
        quiet = 1'b0;

        wait_for_results();
        // Let any stray word the block might still produce show up.
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed) in %0d random segments; checked %0d results.",
                 n_sent, N_DIRECTED, seg, n_results);
        $display("Table peaked at %0d of %0d entries; %s %0d/%0d/%0d/%0d.",
                 peak_count, TABLE_DEPTH, "codes ok/not ready/full/missing:",
                 code_seen[RC_OK], code_seen[RC_NOT_READY],
                 code_seen[RC_FULL], code_seen[RC_MISSING]);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
